// ===== rtl/core/sp_pkg.sv =====
`default_nettype none
package sp_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int VC_W = 7;
	localparam int VTX_W = 7;
	localparam int RAW_W = 10;
	localparam int WGT_W = 20;
	localparam int DIST_W = 32;
	localparam logic [VC_W-1:0] VC_RESET = 7'd64;
	localparam logic [DIST_W-1:0] DIST_INF = '1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_EDGE  = 2'd1,
		OP_SOLVE = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [VTX_W-1:0]   from_vertex;
		logic [VTX_W-1:0]   to_vertex;
		logic [RAW_W-1:0]   edge_weight;
		logic               square_weight;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              reachable;
	} result_t;

	typedef struct packed {
		logic [VC_W-1:0] vertex_count;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EDGE,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_DRAIN,
		ST_DECIDE,
		ST_RELAX,
		ST_RELAX_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic cnt_clr;
		logic cnt_inc;
		logic wm_clear_wr;
		logic edge_wr_fwd;
		logic edge_wr_rev;
		logic load_n;
		logic dist_init_wr;
		logic scan_rd;
		logic pick_clr;
		logic settle_wr;
		logic relax_rd;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic sweep_last;
		logic edge_ok;
		logic found;
		logic pick_last;
		logic res_busy;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/sp_stream_if.sv =====
`default_nettype none
interface sp_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sp_ctrl.sv =====
`default_nettype none
module sp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire sp_pkg::opcode_t    opcode,
	input  wire sp_pkg::dp_status_t status,
	output logic                    in_ready,
	output sp_pkg::dp_cmd_t         cmd
);
	import sp_pkg::*;

	state_t state_q, state_d;
	logic xfer;

	assign xfer = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (xfer) begin
					unique case (opcode)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_EDGE:  state_d = status.edge_ok ? ST_EDGE : ST_IDLE;
						OP_SOLVE: state_d = ST_INIT;
						OP_NOP:   state_d = ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_EDGE:        state_d = ST_IDLE;
			ST_INIT: begin
				if (status.cnt_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.cnt_last) state_d = ST_SCAN_DRAIN;
			end
			ST_SCAN_DRAIN:  state_d = ST_DECIDE;
			ST_DECIDE: begin
				state_d = (!status.found || status.pick_last) ? ST_EMIT : ST_RELAX;
			end
			ST_RELAX: begin
				if (status.cnt_last) state_d = ST_RELAX_DRAIN;
			end
			ST_RELAX_DRAIN: state_d = ST_SCAN;
			ST_EMIT: begin
				if (!status.res_busy) state_d = ST_IDLE;
			end
			default:        state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wm_clear_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cnt_clr = 1'b1;
				if (xfer && opcode == OP_EDGE && status.edge_ok) cmd.edge_wr_fwd = 1'b1;
				if (xfer && opcode == OP_SOLVE) cmd.load_n = 1'b1;
			end
			ST_EDGE: cmd.edge_wr_rev = 1'b1;
			ST_INIT: begin
				cmd.dist_init_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					cmd.pick_clr = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_SCAN_DRAIN: ;
			ST_DECIDE: begin
				cmd.cnt_clr = 1'b1;
				if (status.found && !status.pick_last) cmd.settle_wr = 1'b1;
			end
			ST_RELAX: begin
				cmd.relax_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_RELAX_DRAIN: begin
				cmd.cnt_clr = 1'b1;
				cmd.pick_clr = 1'b1;
			end
			ST_EMIT: begin
				if (!status.res_busy) cmd.res_load = 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/sp_dp.sv =====
`default_nettype none
module sp_dp #(
	parameter int MaxVertices = sp_pkg::MAX_VERTICES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sp_pkg::item_t   item,
	input  wire logic            cfg_we,
	input  wire sp_pkg::cfg_t    cfg_data,
	input  wire sp_pkg::dp_cmd_t cmd,
	output sp_pkg::dp_status_t   status,
	input  wire logic            res_ready,
	output logic                 res_valid,
	output sp_pkg::result_t      res_data
);
	import sp_pkg::*;

	localparam int IW = $clog2(MaxVertices);
	localparam int CW = $clog2(MaxVertices + 1);
	localparam int AW = 2 * IW;

	logic [WGT_W-1:0]  wm_mem [1 << AW];
	logic [DIST_W:0]   dist_mem [1 << IW];

	logic [VC_W-1:0]   vc_q;
	logic [CW-1:0]     n_q, n_m1, n_act;
	logic [AW-1:0]     cnt_q;
	logic [IW-1:0]     idx;
	logic [IW-1:0]     a_q, b_q, a_in, b_in;
	logic [WGT_W-1:0]  w_q, w_in, w_sq;
	logic [IW-1:0]     pick_q;
	logic [DIST_W-1:0] pick_d_q;
	logic              found_q;
	logic              scan_v_s1, relax_v_s1;
	logic [IW-1:0]     j_s1;
	logic [WGT_W-1:0]  w_rd_s1;
	logic [DIST_W:0]   d_rd_s1;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] cand;
	logic              relax_wr;
	logic              wm_we, dm_we;
	logic [AW-1:0]     wm_wa;
	logic [WGT_W-1:0]  wm_wd;
	logic [IW-1:0]     dm_wa;
	logic [DIST_W:0]   dm_wd;
	logic              res_valid_q;
	result_t           res_q;

	assign idx = cnt_q[IW-1:0];
	assign n_m1 = n_q - CW'(1);

	always_comb begin
		int v;
		v = int'(vc_q);
		if (v < 2) v = 2;
		if (v > MaxVertices) v = MaxVertices;
		n_act = CW'(v);
	end

	assign a_in = IW'(item.from_vertex - VTX_W'(1));
	assign b_in = IW'(item.to_vertex - VTX_W'(1));
	assign w_sq = WGT_W'(item.edge_weight) * WGT_W'(item.edge_weight);
	assign w_in = item.square_weight ? w_sq : WGT_W'(item.edge_weight);

	// saturate at infinity
	assign sum = {1'b0, pick_d_q} + (DIST_W+1)'(w_rd_s1);
	assign cand = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
	assign relax_wr = relax_v_s1 && (w_rd_s1 != '0) && !d_rd_s1[DIST_W]
		&& (cand < d_rd_s1[DIST_W-1:0]);

	always_comb begin
		wm_we = 1'b1;
		wm_wa = cnt_q;
		wm_wd = '0;
		priority if (cmd.edge_wr_fwd) begin
			wm_wa = {a_in, b_in};
			wm_wd = w_in;
		end else if (cmd.edge_wr_rev) begin
			wm_wa = {b_q, a_q};
			wm_wd = w_q;
		end else if (cmd.wm_clear_wr) begin
			wm_we = 1'b1;
		end else begin
			wm_we = 1'b0;
		end
	end

	always_comb begin
		dm_we = 1'b1;
		dm_wa = idx;
		dm_wd = {1'b0, DIST_INF};
		priority if (cmd.dist_init_wr) begin
			if (idx == '0) dm_wd = '0;
		end else if (cmd.settle_wr) begin
			dm_wa = pick_q;
			dm_wd = {1'b1, pick_d_q};
		end else if (relax_wr) begin
			dm_wa = j_s1;
			dm_wd = {1'b0, cand};
		end else begin
			dm_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wm_we) wm_mem[wm_wa] <= wm_wd;
		w_rd_s1 <= wm_mem[{pick_q, idx}];
	end

	always_ff @(posedge clk) begin
		if (dm_we) dist_mem[dm_wa] <= dm_wd;
		d_rd_s1 <= dist_mem[idx];
	end

	always_ff @(posedge clk) begin
		j_s1 <= idx;
		if (cmd.edge_wr_fwd) begin
			a_q <= a_in;
			b_q <= b_in;
			w_q <= w_in;
		end
		if (cmd.load_n) n_q <= n_act;
		if (cmd.res_load) begin
			res_q.distance <= found_q ? pick_d_q : DIST_INF;
			res_q.reachable <= found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
			cnt_q <= '0;
			scan_v_s1 <= 1'b0;
			relax_v_s1 <= 1'b0;
			pick_q <= '0;
			pick_d_q <= DIST_INF;
			found_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) vc_q <= cfg_data.vertex_count;
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + AW'(1);
			scan_v_s1 <= cmd.scan_rd;
			relax_v_s1 <= cmd.relax_rd;
			// keep the first unsettled vertex holding the strict minimum
			if (cmd.pick_clr) begin
				pick_q <= '0;
				pick_d_q <= DIST_INF;
				found_q <= 1'b0;
			end else if (scan_v_s1 && !d_rd_s1[DIST_W]
				&& d_rd_s1[DIST_W-1:0] < pick_d_q) begin
				pick_q <= j_s1;
				pick_d_q <= d_rd_s1[DIST_W-1:0];
				found_q <= 1'b1;
			end
			if (cmd.res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.cnt_last = (cnt_q == AW'(n_m1));
		status.sweep_last = &cnt_q;
		status.edge_ok = (item.from_vertex != '0) && (item.to_vertex != '0)
			&& (int'(item.from_vertex) <= MaxVertices)
			&& (int'(item.to_vertex) <= MaxVertices);
		status.found = found_q;
		status.pick_last = (pick_q == n_m1[IW-1:0]);
		status.res_busy = res_valid_q && !res_ready;
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;
endmodule
`default_nettype wire

// ===== rtl/core/shortest_path_to_last_vertex.sv =====
`default_nettype none
// Shortest path from vertex 1 to vertex vertex_count (clamped to 2..MaxVertices) of an
// undirected weighted graph held in an adjacency matrix RAM (one 20-bit word per vertex
// pair). After reset, and after every clear command, the block sweeps the whole matrix,
// all 2**(2*clog2(MaxVertices)) entries (4096 at 64 vertices), with items.ready low. An
// add-edge transfer writes both directions, one after the other, through the single RAM
// write port; no-ops and edges with an out-of-range endpoint write nothing. A solve runs
// Dijkstra with one matrix entry and one distance entry per cycle: it initializes the
// distances, then per settled vertex scans for the minimum, decides and relaxes. The
// result waits in an output register; items.ready comes back once the result has been
// loaded there.
module shortest_path_to_last_vertex #(
	parameter int MaxVertices = sp_pkg::MAX_VERTICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sp_stream_if.sink   items,
	sp_stream_if.source results,
	sp_stream_if.sink   cfg
);
	import sp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       in_ready;

	assign items.ready = in_ready;
	assign cfg.ready = 1'b1;

	sp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.opcode   (items.data.opcode),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	sp_dp #(
		.MaxVertices (MaxVertices)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (items.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.status    (status),
		.res_ready (results.ready),
		.res_valid (results.valid),
		.res_data  (results.data)
	);
endmodule
`default_nettype wire

// ===== rtl/core/sp_checker.sv =====
`default_nettype none
module sp_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire sp_pkg::opcode_t in_opcode,
	input wire logic            res_valid,
	input wire logic            res_ready,
	input wire sp_pkg::result_t res_data
);
	import sp_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result changed while stalled");

	a_reach_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.reachable == (res_data.distance != DIST_INF)))
		else $error("reachable flag disagrees with distance");

	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_opcode == OP_SOLVE || in_opcode == OP_CLEAR)
		|=> !in_ready)
		else $error("input taken during solve or clear");
endmodule

bind shortest_path_to_last_vertex sp_checker u_sp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_opcode (items.data.opcode),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);
`default_nettype wire

// ===== dv/shortest_path_to_last_vertex_test.sv =====
module shortest_path_to_last_vertex_test;
	import sp_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sp_stream_if #(.T(item_t))   items ();
	sp_stream_if #(.T(result_t)) results ();
	sp_stream_if #(.T(cfg_t))    cfg ();

	shortest_path_to_last_vertex uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items.sink),
		.results(results.source),
		.cfg(cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// graph mirror
	logic [WGT_W-1:0] adj [NV][NV];
	logic [VC_W-1:0] vcount;
	result_t pending_paths[$];
	int errors = 0;
	int solves_sent = 0;
	int paths_checked = 0;
	int edges_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	initial begin
		items.valid = 1'b0;
		items.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		results.ready = 1'b0;
	end

	function automatic result_t shortest_path();
		int n;
		int pick;
		bit found;
		logic [DIST_W-1:0] pick_d, cand;
		logic [DIST_W-1:0] best_d [NV];
		bit done [NV];
		logic [DIST_W:0] s;
		result_t r;
		n = vcount < 2 ? 2 : (vcount > NV ? NV : int'(vcount));
		for (int i = 0; i < n; i++) begin
			best_d[i] = DIST_INF;
			done[i] = 1'b0;
		end
		best_d[0] = '0;
		for (int i = 0; i < n; i++) begin
			pick = 0;
			pick_d = DIST_INF;
			found = 1'b0;
			for (int j = 0; j < n; j++)
				if (!done[j] && best_d[j] < pick_d) begin
					pick_d = best_d[j];
					pick = j;
					found = 1'b1;
				end
			if (!found || pick == n - 1) break;
			done[pick] = 1'b1;
			for (int j = 0; j < n; j++)
				if (adj[pick][j] != 0 && !done[j]) begin
					s = {1'b0, pick_d} + adj[pick][j];
					cand = s[DIST_W] ? DIST_INF : s[DIST_W-1:0];
					if (cand < best_d[j]) best_d[j] = cand;
				end
		end
		r.distance = best_d[n-1];
		r.reachable = best_d[n-1] != DIST_INF;
		return r;
	endfunction

	task automatic wait_gap();
		int g;
		g = no_gaps ? 0 : $urandom_range(0, 7);
		if (g != 0) items.valid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic send_item(input item_t it);
		logic [WGT_W-1:0] w;
		wait_gap();
		items.data <= it;
		items.valid <= 1'b1;
		do @(posedge clk); while (!items.ready);
		case (it.opcode)
			OP_CLEAR: begin
				for (int i = 0; i < NV; i++)
					for (int j = 0; j < NV; j++) adj[i][j] = '0;
			end
			OP_EDGE: begin
				w = it.square_weight ? WGT_W'(it.edge_weight) * WGT_W'(it.edge_weight)
					: WGT_W'(it.edge_weight);
				if (it.from_vertex >= 1 && it.to_vertex >= 1 &&
						it.from_vertex <= NV && it.to_vertex <= NV) begin
					adj[it.from_vertex-1][it.to_vertex-1] = w;
					adj[it.to_vertex-1][it.from_vertex-1] = w;
				end
				edges_sent++;
			end
			OP_SOLVE: begin
				pending_paths.push_back(shortest_path());
				solves_sent++;
			end
			default: ;
		endcase
	endtask

	function automatic item_t make_item(opcode_t op, int a, int b, int w, bit sq);
		item_t it;
		it.opcode = op;
		it.from_vertex = VTX_W'(a);
		it.to_vertex = VTX_W'(b);
		it.edge_weight = RAW_W'(w);
		it.square_weight = sq;
		return it;
	endfunction

	task automatic drain();
		items.valid <= 1'b0;
		while (pending_paths.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int v);
		cfg.data <= cfg_t'(VC_W'(v));
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		vcount = VC_W'(v);
	endtask

	// receiver: check each transfer, then a random stall
	initial begin
		result_t want;
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (results.valid && results.ready) begin
				if (pending_paths.size() == 0) begin
					$display("%0t: result with nothing expected: dist %h reach %b", $time,
						results.data.distance, results.data.reachable);
					errors++;
				end else begin
					want = pending_paths.pop_front();
					if (want.distance !== results.data.distance) begin
						$display("%0t: distance expected %h actual %h", $time,
							want.distance, results.data.distance);
						errors++;
					end
					if (want.reachable !== results.data.reachable) begin
						$display("%0t: reachable expected %b actual %b", $time,
							want.reachable, results.data.reachable);
						errors++;
					end
					paths_checked++;
				end
				stall = no_gaps ? 0 : $urandom_range(0, 7);
			end else if (stall > 0) begin
				stall--;
			end
			results.ready <= (stall == 0);
		end
	end

	// watchdog: quiet cycles only
	initial begin
		forever begin
			@(posedge clk);
			if ((items.valid && items.ready) || (results.valid && results.ready) ||
					(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: watchdog expired", $time);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic test_directed();
		send_item(make_item(OP_SOLVE, 1, 1, 0, 0));
		drain();
		set_vertex_count(2);
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		send_item(make_item(OP_EDGE, 1, 2, 1023, 1));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		send_item(make_item(OP_EDGE, 2, 1, 5, 0));
		send_item(make_item(OP_EDGE, 1, 1, 1, 0));
		send_item(make_item(OP_SOLVE, 127, 127, 1023, 1));
		send_item(make_item(OP_EDGE, 0, 2, 1, 0));
		send_item(make_item(OP_EDGE, 1, 127, 1, 0));
		send_item(make_item(OP_EDGE, 65, 64, 1, 1));
		send_item(make_item(OP_NOP, 1, 2, 0, 0));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		send_item(make_item(OP_EDGE, 1, 2, 0, 0));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		drain();
		set_vertex_count(64);
		send_item(make_item(OP_EDGE, 1, 64, 1023, 1));
		send_item(make_item(OP_EDGE, 1, 3, 7, 0));
		send_item(make_item(OP_EDGE, 3, 64, 9, 0));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_count_limits();
		// below 2 and above the maximum clamp
		set_vertex_count(0);
		send_item(make_item(OP_EDGE, 1, 2, 3, 0));
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		drain();
		set_vertex_count(1);
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		drain();
		set_vertex_count(127);
		send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_random_graphs(input int rounds);
		int nv, ne, a, b;
		for (int r = 0; r < rounds; r++) begin
			nv = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 10);
			no_gaps = ($urandom_range(0, 4) == 0);
			drain();
			set_vertex_count(nv);
			if ($urandom_range(0, 2) != 0) send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
			ne = $urandom_range(0, 3 * nv);
			for (int e = 0; e < ne; e++) begin
				case ($urandom_range(0, 19))
					0: send_item(item_t'($bits(item_t)'($urandom)));
					1: send_item(make_item(OP_EDGE, $urandom_range(0, 127),
						$urandom_range(0, 127), $urandom_range(0, 1023), $urandom_range(0, 1)));
					default: begin
						a = $urandom_range(1, nv);
						b = $urandom_range(1, nv);
						send_item(make_item(OP_EDGE, a, b,
							($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1023),
							$urandom_range(0, 1)));
					end
				endcase
			end
			send_item(make_item(OP_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 1023), $urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				send_item(make_item(OP_SOLVE, 0, 0, 0, 0));
		end
		no_gaps = 1'b0;
		drain();
	endtask

	initial begin
		for (int i = 0; i < NV; i++)
			for (int j = 0; j < NV; j++) adj[i][j] = '0;
		vcount = VC_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_count_limits();
		test_random_graphs(45);
		$display("Ran %0d edge loads and %0d solves; %0d distances checked.",
			edges_sent, solves_sent, paths_checked);
		$display("Vertex counts covered both clamps, 2 and 64, plus random graph sizes.");
		if (errors == 0 && pending_paths.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
